// File: hdl/hvb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvb_pkg
// Types, widths, reset values and helpers shared by the boost regulator.
// ----------------------------------------------------------------------------
package hvb_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 10;
  localparam int DUTY_W     = 10;
  localparam int BAND_W     = 8;
  localparam int COUNT_W    = 8;
  localparam int ERR_W      = 12;
  localparam int SUM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [LEVEL_W-1:0] TARGET_RST     = LEVEL_W'(689);
  localparam logic [BAND_W-1:0]  BAND_RST       = BAND_W'(35);
  localparam logic [DUTY_W-1:0]  DUTY_LIMIT_RST = DUTY_W'(180);
  localparam logic [COUNT_W-1:0] LEVEL_TRIP_RST = COUNT_W'(50);
  localparam logic [COUNT_W-1:0] DUTY_TRIP_RST  = COUNT_W'(200);

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_SUPERVISE = 2'd1,
    KIND_RAMP      = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_DUTY = 2'd1,
    FAULT_HIGH = 2'd2,
    FAULT_LOW  = 2'd3
  } fault_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_BAND       = 3'd1,
    REG_DUTY_LIMIT = 3'd2,
    REG_LEVEL_TRIP = 3'd3,
    REG_DUTY_TRIP  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] target_level;
    logic [BAND_W-1:0]  error_band;
    logic [DUTY_W-1:0]  duty_limit;
    logic [COUNT_W-1:0] level_trip_count;
    logic [COUNT_W-1:0] duty_trip_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic [1:0]        fault_code;
    logic              startup_done;
  } out_word_t;

  // Saturating up count
  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    count_up = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

  // Down count that stops at zero
  function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] c);
    count_down = (c == '0) ? c : c - COUNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: hdl/hvb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvb_in_if
// Valid/ready channel carrying one input word (kind and feedback sample).
// ----------------------------------------------------------------------------
interface hvb_in_if;
  logic              valid;
  logic              ready;
  hvb_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/hvb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvb_out_if
// Valid/ready channel carrying one result word (duty, fault, startup status).
// ----------------------------------------------------------------------------
interface hvb_out_if;
  logic               valid;
  logic               ready;
  hvb_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/hvb_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvb_core
// Regulator state and its registered update: PD duty step with clamps,
// band supervision with trip counters, startup ramp and fault latch.
// ----------------------------------------------------------------------------
module hvb_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire hvb_pkg::in_word_t  word,
  input  wire hvb_pkg::cfg_t      cfg,
  output hvb_pkg::out_word_t      result
);

  localparam int LVL_PAD = hvb_pkg::ERR_W - hvb_pkg::LEVEL_W;
  localparam int ERR_PAD = hvb_pkg::SUM_W - hvb_pkg::ERR_W;
  localparam int DUT_PAD = hvb_pkg::SUM_W - hvb_pkg::DUTY_W;
  localparam int BND_PAD = hvb_pkg::ERR_W - hvb_pkg::BAND_W;

  logic [hvb_pkg::DUTY_W-1:0]         duty_level_r, duty_level_nxt;
  logic signed [hvb_pkg::ERR_W-1:0]   last_error_r, last_error_nxt;
  logic [hvb_pkg::LEVEL_W-1:0]        last_sample_r, last_sample_nxt;
  logic [hvb_pkg::DUTY_W-1:0]         startup_limit_r, startup_limit_nxt;
  logic [hvb_pkg::COUNT_W-1:0]        over_count_r, over_count_nxt;
  logic [hvb_pkg::COUNT_W-1:0]        under_count_r, under_count_nxt;
  logic [hvb_pkg::COUNT_W-1:0]        sat_count_r, sat_count_nxt;
  hvb_pkg::fault_t                    fault_r, fault_nxt;

  logic                               update;
  logic signed [hvb_pkg::ERR_W-1:0]   err;
  logic signed [hvb_pkg::ERR_W-1:0]   err_div8;
  logic signed [hvb_pkg::SUM_W-1:0]   duty_sum;
  logic signed [hvb_pkg::SUM_W-1:0]   duty_limit_ext;
  logic signed [hvb_pkg::SUM_W-1:0]   startup_ext;
  logic signed [hvb_pkg::ERR_W-1:0]   band_hi;
  logic signed [hvb_pkg::ERR_W-1:0]   band_lo;
  logic signed [hvb_pkg::ERR_W-1:0]   level_ext;
  logic                               startup_done;

  // Items are ignored once a fault is latched
  assign update = step && (fault_r == hvb_pkg::FAULT_NONE);

  // Control error and its eighth, truncated toward zero
  always_comb begin
    err = $signed({{LVL_PAD{1'b0}}, cfg.target_level})
        - $signed({{LVL_PAD{1'b0}}, word.sample});
    if (err[hvb_pkg::ERR_W-1]) begin
      err_div8 = (err + hvb_pkg::ERR_W'(7)) >>> 3;
    end else begin
      err_div8 = err >>> 3;
    end
    duty_sum = $signed({{DUT_PAD{1'b0}}, duty_level_r})
             + $signed({{ERR_PAD{err_div8[hvb_pkg::ERR_W-1]}}, err_div8})
             + $signed({{ERR_PAD{err[hvb_pkg::ERR_W-1]}}, err})
             - $signed({{ERR_PAD{last_error_r[hvb_pkg::ERR_W-1]}}, last_error_r});
    duty_limit_ext = $signed({{DUT_PAD{1'b0}}, cfg.duty_limit});
    startup_ext    = $signed({{DUT_PAD{1'b0}}, startup_limit_r});
  end

  // Supervision band around the target
  always_comb begin
    band_hi   = $signed({{LVL_PAD{1'b0}}, cfg.target_level})
              + $signed({{BND_PAD{1'b0}}, cfg.error_band});
    band_lo   = $signed({{LVL_PAD{1'b0}}, cfg.target_level})
              - $signed({{BND_PAD{1'b0}}, cfg.error_band});
    level_ext = $signed({{LVL_PAD{1'b0}}, last_sample_r});
    startup_done = (startup_limit_r >= cfg.duty_limit);
  end

  // Next state for the item kind
  always_comb begin
    duty_level_nxt    = duty_level_r;
    last_error_nxt    = last_error_r;
    last_sample_nxt   = last_sample_r;
    startup_limit_nxt = startup_limit_r;
    over_count_nxt    = over_count_r;
    under_count_nxt   = under_count_r;
    sat_count_nxt     = sat_count_r;
    fault_nxt         = fault_r;
    if (update) begin
      case (word.kind)
        hvb_pkg::KIND_SAMPLE: begin
          last_sample_nxt = word.sample;
          last_error_nxt  = err;
          if (duty_sum[hvb_pkg::SUM_W-1]) begin
            duty_level_nxt = '0;
          end else if (duty_sum > duty_limit_ext) begin
            duty_level_nxt = cfg.duty_limit;
            sat_count_nxt  = hvb_pkg::count_up(sat_count_r);
          end else if (duty_sum > startup_ext) begin
            duty_level_nxt = startup_limit_r;
          end else begin
            duty_level_nxt = duty_sum[hvb_pkg::DUTY_W-1:0];
          end
        end
        hvb_pkg::KIND_SUPERVISE: begin
          if (startup_done && (level_ext > band_hi)) begin
            over_count_nxt = hvb_pkg::count_up(over_count_r);
          end else if (startup_done && (level_ext < band_lo)) begin
            under_count_nxt = hvb_pkg::count_up(under_count_r);
          end else begin
            over_count_nxt  = hvb_pkg::count_down(over_count_r);
            under_count_nxt = hvb_pkg::count_down(under_count_r);
          end
          // Trip priority: duty saturation, then high, then low
          if (sat_count_r > cfg.duty_trip_count) begin
            fault_nxt = hvb_pkg::FAULT_DUTY;
          end else if (over_count_nxt > cfg.level_trip_count) begin
            fault_nxt = hvb_pkg::FAULT_HIGH;
          end else if (under_count_nxt > cfg.level_trip_count) begin
            fault_nxt = hvb_pkg::FAULT_LOW;
          end
          if (fault_nxt != hvb_pkg::FAULT_NONE) begin
            duty_level_nxt = '0;
          end
        end
        hvb_pkg::KIND_RAMP: begin
          if (startup_limit_r < cfg.duty_limit) begin
            startup_limit_nxt = startup_limit_r + hvb_pkg::DUTY_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result word reflects the state after this item
  always_comb begin
    result.pwm_duty     = (fault_nxt != hvb_pkg::FAULT_NONE) ? '0 : duty_level_nxt;
    result.fault_code   = fault_nxt;
    result.startup_done = (startup_limit_nxt >= cfg.duty_limit);
  end

  // Hold regulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_level_r    <= '0;
      last_error_r    <= '0;
      last_sample_r   <= '0;
      startup_limit_r <= '0;
      over_count_r    <= '0;
      under_count_r   <= '0;
      sat_count_r     <= '0;
      fault_r         <= hvb_pkg::FAULT_NONE;
    end else begin
      duty_level_r    <= duty_level_nxt;
      last_error_r    <= last_error_nxt;
      last_sample_r   <= last_sample_nxt;
      startup_limit_r <= startup_limit_nxt;
      over_count_r    <= over_count_nxt;
      under_count_r   <= under_count_nxt;
      sat_count_r     <= sat_count_nxt;
      fault_r         <= fault_nxt;
    end
  end

  // A latched fault never clears or changes outside reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != hvb_pkg::FAULT_NONE) |=> (fault_r == $past(fault_r)))
    else $error("latched fault changed");

  // Startup limit only moves up by one
  a_ramp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (startup_limit_r != $past(startup_limit_r)))
      |-> (startup_limit_r == $past(startup_limit_r) + hvb_pkg::DUTY_W'(1)))
    else $error("startup limit moved by other than one");

  // Duty is zero whenever a fault is latched
  a_fault_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != hvb_pkg::FAULT_NONE) |-> (duty_level_r == '0))
    else $error("duty not zero under fault");

endmodule
`default_nettype wire

// File: hdl/hv_boost_regulator_top.sv
// Each accepted word moves from the input register to the result register on out_if.
// One word per cycle while out_if is ready; state update is a single registered pass.
// Backpressure on out_if stalls the input register and then in_if.ready.
// Reset (rst_n low, synchronous): all regulator state zero, no fault, config at
// its default values, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hv_boost_regulator_top
// Supervised PD regulator for a high-voltage boost stage, with config port.
// ----------------------------------------------------------------------------
module hv_boost_regulator_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  hvb_in_if.sink                                  in_if,
  hvb_out_if.source                               out_if,
  input  wire logic                               cfg_we,
  input  wire logic [hvb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hvb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  hvb_pkg::cfg_t      cfg_r;
  logic               s1_valid_r;
  hvb_pkg::in_word_t  s1_word_r;
  logic               out_valid_r;
  hvb_pkg::out_word_t out_word_r;
  hvb_pkg::out_word_t core_result;
  logic               in_accept;
  logic               s1_fire;

  // Pipeline handshake
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_fire;
  assign in_accept   = in_if.valid && in_if.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level     <= hvb_pkg::TARGET_RST;
      cfg_r.error_band       <= hvb_pkg::BAND_RST;
      cfg_r.duty_limit       <= hvb_pkg::DUTY_LIMIT_RST;
      cfg_r.level_trip_count <= hvb_pkg::LEVEL_TRIP_RST;
      cfg_r.duty_trip_count  <= hvb_pkg::DUTY_TRIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hvb_pkg::REG_TARGET:     cfg_r.target_level     <= cfg_wdata[hvb_pkg::LEVEL_W-1:0];
        hvb_pkg::REG_BAND:       cfg_r.error_band       <= cfg_wdata[hvb_pkg::BAND_W-1:0];
        hvb_pkg::REG_DUTY_LIMIT: cfg_r.duty_limit       <= cfg_wdata[hvb_pkg::DUTY_W-1:0];
        hvb_pkg::REG_LEVEL_TRIP: cfg_r.level_trip_count <= cfg_wdata[hvb_pkg::COUNT_W-1:0];
        hvb_pkg::REG_DUTY_TRIP:  cfg_r.duty_trip_count  <= cfg_wdata[hvb_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: capture word, hold while the result side stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept || (s1_valid_r && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_if.data;
    end
  end

  hvb_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_fire),
    .word   (s1_word_r),
    .cfg    (cfg_r),
    .result (core_result)
  );

  // Result register: load on advance, hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_fire || (out_valid_r && !out_if.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_word_r <= core_result;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_word_r;

  // A new result only follows a word waiting in the input register
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a pending word");

  // Reported faults always come with zero duty
  a_fault_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.fault_code != hvb_pkg::FAULT_NONE))
      |-> (out_word_r.pwm_duty == '0))
    else $error("fault reported with nonzero duty");

  // The input register never drops a word while the result side stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_if.ready) |=> s1_valid_r)
    else $error("pending word dropped under stall");

endmodule
`default_nettype wire

// File: dv/hv_boost_regulator_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hv_boost_regulator_top_tb
// Self-checking bench for the supervised boost regulator. A short directed
// table covers reset behavior, clamp extremes, truncation and duty limit
// changes. Random phases follow, each with its own register setting, with
// sample runs drifting around the target so the level counters climb. The
// last phase lets a fault latch. Every result word is checked, against typed
// values for checked rows, else an in-bench copy of the regulator state.
// ----------------------------------------------------------------------------
module hv_boost_regulator_top_tb;
  import hvb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_PHASES  = 8;
  localparam int LAST_PHASE  = NUM_PHASES - 1;
  localparam int PHASE_ITEMS = 130;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PLAN_LEN    = 23;

  typedef struct packed {
    logic                  cfg;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] arg;
    logic [1:0]            kind;
    logic                  chk;
    out_word_t             want;
  } plan_row_t;

  // Directed rows: register writes and words; typed results only where obvious
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    '{1'b0, REG_TARGET, 10'd0,    KIND_SUPERVISE, 1'b1, '{10'd0,   FAULT_NONE, 1'b0}},
    '{1'b0, REG_TARGET, 10'd1023, KIND_UNUSED,    1'b1, '{10'd0,   FAULT_NONE, 1'b0}},
    '{1'b0, REG_TARGET, 10'd1023, KIND_RAMP,      1'b1, '{10'd0,   FAULT_NONE, 1'b0}},
    '{1'b0, REG_TARGET, 10'd0,    KIND_SAMPLE,    1'b1, '{10'd180, FAULT_NONE, 1'b0}},
    '{1'b0, REG_TARGET, 10'd1023, KIND_SAMPLE,    1'b1, '{10'd0,   FAULT_NONE, 1'b0}},
    '{1'b0, REG_TARGET, 10'd689,  KIND_SAMPLE,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd690,  KIND_SAMPLE,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd688,  KIND_SAMPLE,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd698,  KIND_SAMPLE,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd680,  KIND_SAMPLE,    1'b0, '0},
    '{1'b1, REG_DUTY_LIMIT, 10'd2, KIND_SAMPLE,   1'b0, '0},
    '{1'b0, REG_TARGET, 10'd0,    KIND_RAMP,      1'b0, '0},
    '{1'b0, REG_TARGET, 10'd1023, KIND_SAMPLE,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd0,    KIND_SUPERVISE, 1'b0, '0},
    '{1'b0, REG_TARGET, 10'd0,    KIND_SAMPLE,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd0,    KIND_SUPERVISE, 1'b0, '0},
    '{1'b1, REG_DUTY_LIMIT, 10'd1, KIND_SAMPLE,   1'b0, '0},
    '{1'b0, REG_TARGET, 10'd0,    KIND_RAMP,      1'b0, '0},
    '{1'b0, REG_TARGET, 10'd600,  KIND_SAMPLE,    1'b0, '0},
    '{1'b1, REG_DUTY_LIMIT, 10'd0, KIND_SAMPLE,   1'b0, '0},
    '{1'b0, REG_TARGET, 10'd689,  KIND_SAMPLE,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd0,    KIND_UNUSED,    1'b0, '0},
    '{1'b0, REG_TARGET, 10'd0,    KIND_SUPERVISE, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hvb_in_if  in_ch ();
  hvb_out_if out_ch ();

  hv_boost_regulator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Regulator copy: settings
  logic [LEVEL_W-1:0] m_target;
  logic [BAND_W-1:0]  m_band;
  logic [DUTY_W-1:0]  m_dlim;
  logic [COUNT_W-1:0] m_ltrip;
  logic [COUNT_W-1:0] m_dtrip;

  // Regulator copy: loop and supervision state
  logic [DUTY_W-1:0]        m_duty;
  logic signed [ERR_W-1:0]  m_last_err;
  logic [SAMPLE_W-1:0]      m_last_samp;
  logic [DUTY_W-1:0]        m_ramp;
  logic [COUNT_W-1:0]       m_over;
  logic [COUNT_W-1:0]       m_under;
  logic [COUNT_W-1:0]       m_sat;
  fault_t                   m_fault;

  out_word_t duty_reports_q [$];
  int        mismatch_cnt = 0;
  int        idle_cycles  = 0;
  bit        hold_req     = 1'b0;
  bit        rx_stall_en  = 1'b1;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the regulator copy by one word and return the report it gives
  function automatic out_word_t regulate(input in_word_t w);
    int        err;
    int        d;
    int        hi;
    int        lo;
    bit        done;
    out_word_t o;
    if (m_fault == FAULT_NONE) begin
      case (w.kind)
        KIND_SAMPLE: begin
          err = int'(m_target) - int'(w.sample);
          m_last_samp = w.sample;
          d = int'(m_duty) + err / 8 + (err - int'(m_last_err));
          if (err > 2047) err = 2047;
          if (err < -2048) err = -2048;
          m_last_err = ERR_W'(err);
          if (d < 0) begin
            d = 0;
          end else if (d > int'(m_dlim)) begin
            d = int'(m_dlim);
            if (m_sat != COUNT_MAX) m_sat = m_sat + 1'b1;
          end else if (d > int'(m_ramp)) begin
            d = int'(m_ramp);
          end
          m_duty = DUTY_W'(d);
        end
        KIND_SUPERVISE: begin
          hi = int'(m_target) + int'(m_band);
          lo = int'(m_target) - int'(m_band);
          done = (m_ramp >= m_dlim);
          if (done && int'(m_last_samp) > hi) begin
            if (m_over != COUNT_MAX) m_over = m_over + 1'b1;
          end else if (done && int'(m_last_samp) < lo) begin
            if (m_under != COUNT_MAX) m_under = m_under + 1'b1;
          end else begin
            if (m_over != '0) m_over = m_over - 1'b1;
            if (m_under != '0) m_under = m_under - 1'b1;
          end
          // Trip priority: duty saturation, then high, then low
          if (m_sat > m_dtrip) m_fault = FAULT_DUTY;
          else if (m_over > m_ltrip) m_fault = FAULT_HIGH;
          else if (m_under > m_ltrip) m_fault = FAULT_LOW;
          if (m_fault != FAULT_NONE) m_duty = '0;
        end
        KIND_RAMP: begin
          if (m_ramp < m_dlim) m_ramp = m_ramp + 1'b1;
        end
        default: begin
        end
      endcase
    end
    o.pwm_duty     = (m_fault != FAULT_NONE) ? '0 : m_duty;
    o.fault_code   = m_fault;
    o.startup_done = (m_ramp >= m_dlim);
    return o;
  endfunction

  // Offer one word, hold it until taken, then log its predicted report
  task automatic send_word(input in_word_t w, input logic chk, input out_word_t want);
    out_word_t model_word;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    model_word = regulate(w);
    duty_reports_q.push_back(chk ? want : model_word);
  endtask

  // Drop valid and wait for every pending report plus the pipeline depth
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (duty_reports_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_TARGET:     m_target = val[LEVEL_W-1:0];
      REG_BAND:       m_band   = val[BAND_W-1:0];
      REG_DUTY_LIMIT: m_dlim   = val[DUTY_W-1:0];
      REG_LEVEL_TRIP: m_ltrip  = val[COUNT_W-1:0];
      REG_DUTY_TRIP:  m_dtrip  = val[COUNT_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Result side: random ready bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!rx_stall_en || $urandom_range(0, 99) >= 30) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Compare each taken report with the oldest prediction
  always @(posedge clk) begin : check_reports
    out_word_t want;
    out_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (duty_reports_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: duty %0d fault %0d done %0b",
                   got.pwm_duty, got.fault_code, got.startup_done);
      end else begin
        want = duty_reports_q.pop_front();
        if (got.pwm_duty !== want.pwm_duty || got.fault_code !== want.fault_code ||
            got.startup_done !== want.startup_done) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch (exp/act): duty %0d/%0d fault %0d/%0d done %0b/%0b",
                     want.pwm_duty, got.pwm_duty, want.fault_code, got.fault_code,
                     want.startup_done, got.startup_done);
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    in_word_t              w;
    int                    drift;
    int                    span;
    int                    s;
    int                    pick;
    int                    gap_pct;
    logic [CFG_DATA_W-1:0] target_v;
    logic [CFG_DATA_W-1:0] band_v;
    logic [CFG_DATA_W-1:0] dlim_v;
    logic [CFG_DATA_W-1:0] ltrip_v;
    logic [CFG_DATA_W-1:0] dtrip_v;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;

    m_target    = TARGET_RST;
    m_band      = BAND_RST;
    m_dlim      = DUTY_LIMIT_RST;
    m_ltrip     = LEVEL_TRIP_RST;
    m_dtrip     = DUTY_TRIP_RST;
    m_duty      = '0;
    m_last_err  = '0;
    m_last_samp = '0;
    m_ramp      = '0;
    m_over      = '0;
    m_under     = '0;
    m_sat       = '0;
    m_fault     = FAULT_NONE;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].cfg) begin
        cfg_write(PLAN[i].idx, PLAN[i].arg);
      end else begin
        w.kind   = PLAN[i].kind;
        w.sample = PLAN[i].arg;
        send_word(w, PLAN[i].chk, PLAN[i].want);
      end
    end

    // Random phases, each with its own setting; the last one may trip a fault
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          target_v = CFG_DATA_W'(TARGET_RST);
          band_v   = CFG_DATA_W'($urandom_range(0, 255));
          dlim_v   = CFG_DATA_W'($urandom_range(1, 40));
        end
        1: begin
          target_v = '0;
          band_v   = '0;
          dlim_v   = CFG_DATA_W'(1023);
        end
        2: begin
          target_v = CFG_DATA_W'(1023);
          band_v   = CFG_DATA_W'(255);
          dlim_v   = '0;
        end
        3: begin
          // Lower bound below zero
          target_v = CFG_DATA_W'(10);
          band_v   = CFG_DATA_W'(200);
          dlim_v   = CFG_DATA_W'(5);
        end
        LAST_PHASE: begin
          target_v = CFG_DATA_W'($urandom_range(0, 1023));
          band_v   = CFG_DATA_W'($urandom_range(0, 40));
          dlim_v   = CFG_DATA_W'($urandom_range(0, 30));
        end
        default: begin
          // Upper data bits of the 8-bit registers are random and must drop
          target_v = CFG_DATA_W'($urandom_range(0, 1023));
          band_v   = CFG_DATA_W'($urandom_range(0, 1023));
          dlim_v   = CFG_DATA_W'($urandom_range(0, 60));
        end
      endcase
      if (phase != LAST_PHASE) begin
        // Counters saturate at the maximum, so these thresholds never trip
        ltrip_v = {2'($urandom_range(0, 3)), COUNT_MAX};
        dtrip_v = {2'($urandom_range(0, 3)), COUNT_MAX};
      end else if ($urandom_range(0, 1) == 0) begin
        ltrip_v = ($urandom_range(0, 1) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 30));
        dtrip_v = CFG_DATA_W'(COUNT_MAX);
      end else begin
        ltrip_v = CFG_DATA_W'(COUNT_MAX);
        dtrip_v = CFG_DATA_W'($urandom_range(0, 40));
      end

      cfg_write(REG_TARGET, target_v);
      cfg_write(REG_BAND, band_v);
      cfg_write(REG_DUTY_LIMIT, dlim_v);
      cfg_write(REG_LEVEL_TRIP, ltrip_v);
      cfg_write(REG_DUTY_TRIP, dtrip_v);

      if (phase == LAST_PHASE) begin
        gap_pct     = 0;
        rx_stall_en = 1'b0;
      end else begin
        pick        = int'($urandom_range(0, 2));
        gap_pct     = (pick == 0) ? 0 : (pick == 1) ? 8 : 25;
        rx_stall_en = ($urandom_range(0, 3) != 0);
      end
      span  = int'(m_band) + 60;
      drift = 0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Move the drift now and then so samples sit off target for a while
        if ($urandom_range(0, 19) == 0)
          drift = int'($urandom_range(0, 2 * span)) - span;

        w.sample = SAMPLE_W'($urandom_range(0, 1023));
        if (m_ramp < m_dlim && $urandom_range(0, 2) == 0) begin
          w.kind = KIND_RAMP;
        end else begin
          pick = int'($urandom_range(0, 99));
          if (pick < 50) begin
            w.kind = KIND_SAMPLE;
            if ($urandom_range(0, 99) < 65) begin
              s = int'(m_target) + drift + int'($urandom_range(0, 6)) - 3;
              if (s < 0) s = 0;
              if (s > 1023) s = 1023;
              w.sample = SAMPLE_W'(s);
            end
          end else if (pick < 75) begin
            w.kind = KIND_SUPERVISE;
          end else if (pick < 95) begin
            w.kind = KIND_RAMP;
          end else begin
            w.kind = KIND_UNUSED;
          end
        end
        send_word(w, 1'b0, '0);

        // Long receiver hold-off while words keep coming
        if (phase == 2 && n == 40) hold_req = 1'b1;
        // Sender pause until every report is back
        if (phase == 4 && n == 60) begin
          wait_drained();
        end else if (!hold_req && int'($urandom_range(0, 99)) < gap_pct) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
      end
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    while (duty_reports_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && duty_reports_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
